FILE: rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the button press classifier
// Time width, register codes, press classes and the state/config records.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int TIME_WIDTH   = 32;
    localparam int THRESH_WIDTH = 16;
    localparam int DEBOUNCE_W   = 10;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [THRESH_WIDTH-1:0] MEDIUM_RESET   = 16'd3000;
    localparam logic [THRESH_WIDTH-1:0] LONG_RESET     = 16'd6000;
    localparam logic [DEBOUNCE_W-1:0]   DEBOUNCE_RESET = 10'd50;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MEDIUM   = 2'd0,
        CFG_LONG     = 2'd1,
        CFG_DEBOUNCE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_SHORT  = 2'd1,
        ACT_MEDIUM = 2'd2,
        ACT_LONG   = 2'd3
    } action_t;

    typedef logic [TIME_WIDTH-1:0] time_ms_t;

    typedef struct packed {
        logic [THRESH_WIDTH-1:0] medium_threshold_ms;
        logic [THRESH_WIDTH-1:0] long_threshold_ms;
        logic [DEBOUNCE_W-1:0]   settle_ms;
    } bpc_cfg_t;

    typedef struct packed {
        logic     is_pressed;
        logic     long_done;
        logic     last_level;
        time_ms_t change_time;
        time_ms_t press_start;
    } bpc_state_t;

endpackage

FILE: rtl/bpc_req_if.sv
// ----------------------------------------------------------------------------
// bpc_req_if: poll request channel
// Carries one poll: time, raw level and a captured falling edge.
// ----------------------------------------------------------------------------
interface bpc_req_if;
    import bpc_pkg::*;

    logic     valid;
    logic     ready;
    time_ms_t now_ms;
    logic     raw_pressed;
    logic     edge_seen;
    time_ms_t edge_time_ms;

    modport source (output valid, output now_ms, output raw_pressed,
                    output edge_seen, output edge_time_ms, input ready);
    modport sink   (input valid, input now_ms, input raw_pressed,
                    input edge_seen, input edge_time_ms, output ready);
endinterface

FILE: rtl/bpc_res_if.sv
// ----------------------------------------------------------------------------
// bpc_res_if: classification result channel
// Carries the press class and the current hold time.
// ----------------------------------------------------------------------------
interface bpc_res_if;
    import bpc_pkg::*;

    logic     valid;
    logic     ready;
    logic [1:0] action;
    time_ms_t hold_ms;

    modport source (output valid, output action, output hold_ms, input ready);
    modport sink   (input valid, input action, input hold_ms, output ready);
endinterface

FILE: rtl/button_press_classifier_top.sv
// ----------------------------------------------------------------------------
// button_press_classifier_top: debounced short/medium/long press classifier
// Poll register, classifier, state and result register with handshakes.
// ----------------------------------------------------------------------------
// Each request is one poll of the button and yields exactly one result: the
// press class (none, short, medium, long) and the hold time after the poll.
// The block takes one request per clock while the result side is not stalled: the
// poll is captured in an input register, classified by combinational logic
// against the stored button state, and the result lands in an output register
// that holds while the consumer stalls. The state loop (press start, change
// time, flags) is committed as each poll moves to the result register, so
// back-to-back polls see each other's updates. Thresholds and debounce time are written
// through the plain write port and must only change while no request is in flight.
module button_press_classifier_top
    import bpc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    bpc_req_if.sink                req,
    bpc_res_if.source              res
);

    bpc_cfg_t   cfg;
    bpc_state_t state_reg;
    bpc_state_t state_next;
    bpc_state_t state_calc;
    action_t    action_calc;
    time_ms_t   hold_calc;

    // input register
    logic       in_valid_reg;
    time_ms_t   now_reg;
    logic       raw_reg;
    logic       edge_reg;
    time_ms_t   etime_reg;

    // result register
    logic       out_valid_reg;
    action_t    action_reg;
    time_ms_t   hold_reg;

    logic       out_free;
    logic       advance;
    logic       take;

    bpc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bpc_classify u_classify
    (
        .cfg          (cfg),
        .state_cur    (state_reg),
        .now_ms       (now_reg),
        .raw_pressed  (raw_reg),
        .edge_seen    (edge_reg),
        .edge_time_ms (etime_reg),
        .state_new    (state_calc),
        .action       (action_calc),
        .hold_ms      (hold_calc)
    );

    // advance the captured poll whenever the result register can take it
    assign out_free  = !out_valid_reg || res.ready;
    assign advance   = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || out_free;
    assign take      = req.valid && req.ready;

    // commit the state only when the poll actually moves to the result side
    assign state_next = advance ? state_calc : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req.ready)
                in_valid_reg <= req.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload registers: poll fields load on capture, result fields on advance; hold otherwise
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            now_reg   <= req.now_ms;
            raw_reg   <= req.raw_pressed;
            edge_reg  <= req.edge_seen;
            etime_reg <= req.edge_time_ms;
        end
        if (advance)
        begin
            action_reg <= action_calc;
            hold_reg   <= hold_calc;
        end
    end

    assign res.valid   = out_valid_reg;
    assign res.action  = action_reg;
    assign res.hold_ms = hold_reg;

endmodule

FILE: rtl/bpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpc_cfg_regs: threshold and debounce registers
// Write-only register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bpc_cfg_regs
    import bpc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output bpc_cfg_t               cfg
);

    bpc_cfg_t cfg_reg;
    bpc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MEDIUM:   cfg_next.medium_threshold_ms = cfg_wdata[THRESH_WIDTH-1:0];
                CFG_LONG:     cfg_next.long_threshold_ms   = cfg_wdata[THRESH_WIDTH-1:0];
                CFG_DEBOUNCE: cfg_next.settle_ms           = cfg_wdata[DEBOUNCE_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.medium_threshold_ms <= MEDIUM_RESET;
            cfg_reg.long_threshold_ms   <= LONG_RESET;
            cfg_reg.settle_ms           <= DEBOUNCE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/bpc_classify.sv
// ----------------------------------------------------------------------------
// bpc_classify: one-poll classifier datapath
// Computes next button state, press class and hold time for one poll.
// ----------------------------------------------------------------------------
module bpc_classify
    import bpc_pkg::*;
(
    input  bpc_cfg_t   cfg,
    input  bpc_state_t state_cur,
    input  time_ms_t   now_ms,
    input  logic       raw_pressed,
    input  logic       edge_seen,
    input  time_ms_t   edge_time_ms,
    output bpc_state_t state_new,
    output action_t    action,
    output time_ms_t   hold_ms
);

    time_ms_t debounce_ext;
    time_ms_t long_ext;
    time_ms_t medium_ext;
    time_ms_t edge_age;
    time_ms_t change_ct;
    time_ms_t stable_age;
    time_ms_t held;
    logic     edge_idle;
    logic     old_enough;

    assign debounce_ext = TIME_WIDTH'(cfg.settle_ms);
    assign long_ext     = TIME_WIDTH'(cfg.long_threshold_ms);
    assign medium_ext   = TIME_WIDTH'(cfg.medium_threshold_ms);

    assign edge_idle  = edge_seen && !state_cur.is_pressed;
    assign edge_age   = now_ms - edge_time_ms;
    assign old_enough = edge_age >= debounce_ext;

    // level tracking for the plain poll path
    assign change_ct  = (raw_pressed != state_cur.last_level) ? now_ms
                                                              : state_cur.change_time;
    assign stable_age = now_ms - change_ct;
    assign held       = now_ms - state_cur.press_start;

    always_comb
    begin
        state_new = state_cur;
        action    = ACT_NONE;
        if (edge_idle && !raw_pressed)
        begin
            // press already over between polls: report, touch nothing
            action = old_enough ? ACT_SHORT : ACT_NONE;
        end
        else if (edge_idle && old_enough)
        begin
            // back-date the press start to the captured edge
            state_new.press_start = edge_time_ms;
            state_new.is_pressed  = 1'b1;
            state_new.last_level  = 1'b1;
            state_new.change_time = edge_time_ms;
            state_new.long_done   = 1'b0;
            if (edge_age >= long_ext)
            begin
                state_new.long_done = 1'b1;
                action              = ACT_LONG;
            end
        end
        else
        begin
            state_new.last_level  = raw_pressed;
            state_new.change_time = change_ct;
            if (stable_age >= debounce_ext)
            begin
                if (raw_pressed && !state_cur.is_pressed)
                begin
                    state_new.press_start = now_ms;
                    state_new.is_pressed  = 1'b1;
                    state_new.long_done   = 1'b0;
                end
                else if (raw_pressed && state_cur.is_pressed && !state_cur.long_done
                         && held >= long_ext)
                begin
                    state_new.long_done = 1'b1;
                    action              = ACT_LONG;
                end
                else if (!raw_pressed && state_cur.is_pressed)
                begin
                    state_new.is_pressed = 1'b0;
                    if (state_cur.long_done)
                        action = ACT_NONE;
                    else if (medium_ext != '0 && held >= medium_ext)
                        action = ACT_MEDIUM;
                    else
                        action = ACT_SHORT;
                end
            end
        end
    end

    // hold time is taken from the updated state; a start ahead of now reads zero
    assign hold_ms = (state_new.is_pressed && now_ms >= state_new.press_start)
                     ? (now_ms - state_new.press_start) : '0;

endmodule
